// ----- design/pwfr_pkg.sv -----
// Package for the pulse-width frame receiver.
// Holds result event codes, register indexes and reset values of the settings.
// No dependencies.
package pwfr_pkg;

  // Result event codes
  localparam logic [1:0] EV_BYTE      = 2'd0;
  localparam logic [1:0] EV_FRAME_END = 2'd1;
  localparam logic [1:0] EV_FRAME_ERR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ZERO_BIT_MIN_LOW = 2'd0;
  localparam logic [1:0] REG_SYNC_LOW_ABOVE   = 2'd1;
  localparam logic [1:0] REG_SYNC_LOW_BELOW   = 2'd2;
  localparam logic [1:0] REG_END_GAP_TICKS    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0] ZERO_BIT_MIN_LOW_RST = 8'd3;
  localparam logic [7:0] SYNC_LOW_ABOVE_RST   = 8'd25;
  localparam logic [7:0] SYNC_LOW_BELOW_RST   = 8'd45;
  localparam logic [7:0] END_GAP_TICKS_RST    = 8'd40;

  // Saturation limit of the run and byte counters
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef logic [1:0] event_kind_t;

endpackage

// ----- design/pulse_width_frame_receiver.sv -----
// Top level of the pulse-width single-wire frame receiver.
// Depends on pwfr_pkg.
//
// Usage: each input transfer on in_* is one sample tick of the line
// (in_line_level). The block measures low periods between edges. Outside a
// frame, a low period strictly between sync_low_above and sync_low_below
// opens a frame; inside it every low period is a bit (short = 1, long = 0),
// shifted in LSB first. Each completed byte is reported as a transfer on
// out_* with kind byte; a high gap of end_gap_ticks closes the frame with a
// frame end (byte aligned and non-empty) or a frame error.
// A result is registered and shows on out_* in the cycle after the sample that causes it.
// Throughput: one sample per cycle; all decode logic sits between the state
// registers and the single output register. in_ready stays high while the
// output register is empty or being taken, so a stalled receiver holds
// in_ready low only while a result is waiting.
// Configuration: cfg_we writes cfg_data into register cfg_index at once.
// Reset (synchronous, rst_n low) clears the line state, drops out_valid and
// restores the register defaults 3, 25, 45 and 40.
module pulse_width_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  // sample input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_line_level,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_byte_total,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers
  logic [7:0] zero_bit_min_low_r;
  logic [7:0] sync_low_above_r;
  logic [7:0] sync_low_below_r;
  logic [7:0] end_gap_ticks_r;

  // Line state
  logic       prev_level_r, prev_level_nxt;
  logic [7:0] run_count_r, run_count_nxt;
  logic [2:0] bit_index_r, bit_index_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic       armed_r, armed_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  pwfr_pkg::event_kind_t out_kind_r, out_kind_nxt;
  logic [7:0]            out_value_r, out_value_nxt;
  logic [7:0]            out_total_r, out_total_nxt;

  logic       in_xfer;
  logic       emit;
  logic [7:0] run_inc;
  logic [7:0] byte_inc;
  logic       bit_val;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign run_inc  = (run_count_r  == pwfr_pkg::COUNT_MAX) ? run_count_r  : run_count_r + 8'd1;
  assign byte_inc = (byte_index_r == pwfr_pkg::COUNT_MAX) ? byte_index_r : byte_index_r + 8'd1;
  assign bit_val  = (run_count_r < zero_bit_min_low_r);

  // Per-sample decode
  always_comb begin
    prev_level_nxt = prev_level_r;
    run_count_nxt  = run_count_r;
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    shift_byte_nxt = shift_byte_r;
    in_frame_nxt   = in_frame_r;
    armed_nxt      = armed_r;
    emit           = 1'b0;
    out_kind_nxt   = pwfr_pkg::EV_BYTE;
    out_value_nxt  = 8'd0;
    out_total_nxt  = 8'd0;

    if (!in_line_level) begin
      // low sample: restart on falling edge, else count
      if (prev_level_r) begin
        prev_level_nxt = 1'b0;
        run_count_nxt  = 8'd0;
      end else begin
        run_count_nxt = run_inc;
      end
    end else if (!prev_level_r) begin
      // rising edge: run_count_r is the low length
      prev_level_nxt = 1'b1;
      run_count_nxt  = 8'd0;
      if (in_frame_r) begin
        shift_byte_nxt = {bit_val, shift_byte_r[7:1]};
        bit_index_nxt  = bit_index_r + 3'd1;
        if (bit_index_r == 3'd7) begin
          byte_index_nxt = byte_inc;
          emit           = 1'b1;
          out_kind_nxt   = pwfr_pkg::EV_BYTE;
          out_value_nxt  = {bit_val, shift_byte_r[7:1]};
          out_total_nxt  = byte_inc;
        end
      end else if (run_count_r > sync_low_above_r && run_count_r < sync_low_below_r) begin
        in_frame_nxt = 1'b1;
        armed_nxt    = 1'b1;
      end
    end else begin
      // high run: look for the end gap
      run_count_nxt = run_inc;
      if (armed_r && run_inc >= end_gap_ticks_r) begin
        emit           = 1'b1;
        out_total_nxt  = byte_index_r;
        byte_index_nxt = 8'd0;
        in_frame_nxt   = 1'b0;
        armed_nxt      = 1'b0;
        if (bit_index_r == 3'd0 && byte_index_r != 8'd0) begin
          out_kind_nxt = pwfr_pkg::EV_FRAME_END;
        end else begin
          out_kind_nxt  = pwfr_pkg::EV_FRAME_ERR;
          run_count_nxt = 8'd0;
          bit_index_nxt = 3'd0;
        end
      end
    end
  end

  // Output valid: a new sample only enters when the register frees up
  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      run_count_r  <= 8'd0;
      bit_index_r  <= 3'd0;
      byte_index_r <= 8'd0;
      shift_byte_r <= 8'd0;
      in_frame_r   <= 1'b0;
      armed_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        prev_level_r <= prev_level_nxt;
        run_count_r  <= run_count_nxt;
        bit_index_r  <= bit_index_nxt;
        byte_index_r <= byte_index_nxt;
        shift_byte_r <= shift_byte_nxt;
        in_frame_r   <= in_frame_nxt;
        armed_r      <= armed_nxt;
      end
    end
  end

  // Result payload, loaded with each new result
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_total_r <= out_total_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_bit_min_low_r <= pwfr_pkg::ZERO_BIT_MIN_LOW_RST;
      sync_low_above_r   <= pwfr_pkg::SYNC_LOW_ABOVE_RST;
      sync_low_below_r   <= pwfr_pkg::SYNC_LOW_BELOW_RST;
      end_gap_ticks_r    <= pwfr_pkg::END_GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pwfr_pkg::REG_ZERO_BIT_MIN_LOW: zero_bit_min_low_r <= cfg_data;
        pwfr_pkg::REG_SYNC_LOW_ABOVE:   sync_low_above_r   <= cfg_data;
        pwfr_pkg::REG_SYNC_LOW_BELOW:   sync_low_below_r   <= cfg_data;
        pwfr_pkg::REG_END_GAP_TICKS:    end_gap_ticks_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_byte_value = out_value_r;
  assign out_byte_total = out_total_r;

endmodule

// ----- design/pwfr_checker.sv -----
// Port-level checker for pulse_width_frame_receiver, attached by bind.
// Depends on pwfr_pkg.
module pwfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_kind,
  input logic [7:0] out_byte_value,
  input logic [7:0] out_byte_total
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds its kind
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // only byte results carry a value, and no unused code appears
  a_value_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != pwfr_pkg::EV_BYTE |->
      out_byte_value == 8'd0 &&
      (out_event_kind == pwfr_pkg::EV_FRAME_END || out_event_kind == pwfr_pkg::EV_FRAME_ERR))
    else $error("bad non-byte result");

  // a good frame end or a byte always has a nonzero count
  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == pwfr_pkg::EV_FRAME_END ||
                  out_event_kind == pwfr_pkg::EV_BYTE) |-> out_byte_total != 8'd0)
    else $error("zero byte count on byte or frame end");

endmodule

bind pulse_width_frame_receiver pwfr_checker u_pwfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_kind (out_event_kind),
  .out_byte_value (out_byte_value),
  .out_byte_total (out_byte_total)
);

// ----- tb/frame_event_checker.sv -----
// Scoreboard for the pulse-width frame receiver: tracks line samples and config writes,
// predicts byte, frame end and frame error results, and compares every output transfer.
// Depends on pwfr_pkg.
module frame_event_checker
  import pwfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_line_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_event_kind,
  input  logic [7:0]  out_byte_value,
  input  logic [7:0]  out_byte_total,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  value;
    logic [7:0]  total;
  } frame_event_t;

  // Shadow copy of the settings
  logic [7:0] zero_min, sync_above, sync_below, end_gap;

  // Shadow copy of the line decoder
  logic       line_hi;
  logic [7:0] run_len;
  logic [2:0] bit_pos;
  logic [7:0] byte_cnt;
  logic [7:0] shreg;
  logic       framing;
  logic       armed;

  frame_event_t expected_events[$];

  task automatic post_event(input event_kind_t kind, input logic [7:0] value,
                            input logic [7:0] total);
    frame_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    ev.total = total;
    expected_events.push_back(ev);
  endtask

  // One line sample through the decoder
  task automatic decode_tick(input logic lvl);
    logic [7:0] low_len;
    logic       one;
    if (!lvl) begin
      // falling edge restarts the count, the high length is dropped
      if (line_hi) begin
        line_hi = 1'b0;
        run_len = '0;
      end else if (run_len != COUNT_MAX) begin
        run_len++;
      end
    end else if (!line_hi) begin
      // rising edge: the low period just ended is a bit or a sync
      low_len = run_len;
      line_hi = 1'b1;
      run_len = '0;
      if (framing) begin
        one     = (low_len < zero_min);
        shreg   = {one, shreg[7:1]};
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          if (byte_cnt != COUNT_MAX) byte_cnt++;
          post_event(EV_BYTE, shreg, byte_cnt);
        end
      end else if (low_len > sync_above && low_len < sync_below) begin
        framing = 1'b1;
        armed   = 1'b1;
      end
    end else begin
      // high level held: watch for the end gap
      if (run_len != COUNT_MAX) run_len++;
      if (armed && run_len >= end_gap) begin
        if (bit_pos == 3'd0 && byte_cnt != 8'd0) begin
          post_event(EV_FRAME_END, 8'd0, byte_cnt);
        end else begin
          post_event(EV_FRAME_ERR, 8'd0, byte_cnt);
          run_len = '0;
          bit_pos = '0;
        end
        byte_cnt = '0;
        framing  = 1'b0;
        armed    = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_event_t want;
    if (!rst_n) begin
      zero_min   = ZERO_BIT_MIN_LOW_RST;
      sync_above = SYNC_LOW_ABOVE_RST;
      sync_below = SYNC_LOW_BELOW_RST;
      end_gap    = END_GAP_TICKS_RST;
      line_hi    = 1'b0;
      run_len    = '0;
      bit_pos    = '0;
      byte_cnt   = '0;
      shreg      = '0;
      framing    = 1'b0;
      armed      = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ZERO_BIT_MIN_LOW: zero_min   = cfg_data;
          REG_SYNC_LOW_ABOVE:   sync_above = cfg_data;
          REG_SYNC_LOW_BELOW:   sync_below = cfg_data;
          REG_END_GAP_TICKS:    end_gap    = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) decode_tick(in_line_level);

      // compare each result transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_kind %0d byte_value %0d byte_total %0d",
                 out_event_kind, out_byte_value, out_byte_total);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, out_event_kind);
            mismatches++;
          end
          if (out_byte_value !== want.value) begin
            $error("byte_value: expected %0d, actual %0d", want.value, out_byte_value);
            mismatches++;
          end
          if (out_byte_total !== want.total) begin
            $error("byte_total: expected %0d, actual %0d", want.total, out_byte_total);
            mismatches++;
          end
        end
      end
    end
    waiting = expected_events.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the pulse-width frame receiver testbench: clock, reset, line sample stimulus,
// settings writes, output back-pressure and the verdict.
// Depends on pwfr_pkg, pulse_width_frame_receiver and frame_event_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwfr_pkg::*;

  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_LEN    = 400;
  localparam int         ITEM_TARGET = 1000;
  localparam logic [7:0] DIR_BYTE    = 8'hEE;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_line_level = 1'b0;
  logic       out_ready     = 1'b0;
  logic       cfg_we        = 1'b0;
  logic [1:0] cfg_index     = '0;
  logic [7:0] cfg_data      = '0;

  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_event_kind;
  logic [7:0] out_byte_value;
  logic [7:0] out_byte_total;

  int mismatches;
  int waiting;

  // settings as last written, used to shape the line patterns
  int zmin_set  = int'(ZERO_BIT_MIN_LOW_RST);
  int above_set = int'(SYNC_LOW_ABOVE_RST);
  int below_set = int'(SYNC_LOW_BELOW_RST);
  int gap_set   = int'(END_GAP_TICKS_RST);

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   ticks_sent    = 0;
  int   cycle_cnt     = 0;
  logic in_fire       = 1'b0;
  logic hold_req      = 1'b0;
  bit   hold_done     = 1'b0;
  int   hold_cycles   = 0;

  always #5 clk = ~clk;

  pulse_width_frame_receiver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_byte_value(out_byte_value),
    .out_byte_total(out_byte_total),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_event_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_kind(out_event_kind),
    .out_byte_value(out_byte_value),
    .out_byte_total(out_byte_total),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .waiting       (waiting)
  );

  // input transfer flag sampled at the rising edge
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // n samples at one level, each waiting for its transfer
  task automatic send_run(input logic lvl, input int n);
    repeat (n) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_line_level <= lvl;
      @(negedge clk);
      while (!in_fire) @(negedge clk);
      ticks_sent++;
    end
  endtask

  // drop valid and let every predicted result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] z, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] g);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ZERO_BIT_MIN_LOW;
    cfg_data  <= z;
    @(negedge clk);
    cfg_index <= REG_SYNC_LOW_ABOVE;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= REG_SYNC_LOW_BELOW;
    cfg_data  <= b;
    @(negedge clk);
    cfg_index <= REG_END_GAP_TICKS;
    cfg_data  <= g;
    @(negedge clk);
    cfg_we    <= 1'b0;
    zmin_set  = int'(z);
    above_set = int'(a);
    below_set = int'(b);
    gap_set   = int'(g);
  endtask

  // low length (in counts) for one random data bit
  function automatic int bit_low_len();
    int lim;
    bit one;
    if (zmin_set == 0) one = 1'b0;
    else if (zmin_set > 32) one = ($urandom_range(7) != 0);
    else one = 1'($urandom_range(1));
    if (one) begin
      lim = zmin_set - 1;
      if (lim > 5) lim = 5;
      return $urandom_range(lim);
    end
    // now and then a low long enough to saturate the run counter
    if ($urandom_range(99) == 0) return 255 + $urandom_range(20);
    lim = 255 - zmin_set;
    if (lim > 4) lim = 4;
    return zmin_set + $urandom_range(lim);
  endfunction

  // mostly whole bytes, sometimes a ragged or empty frame
  function automatic int pick_bits(input int max_bytes);
    if ($urandom_range(5) == 0) return $urandom_range(20);
    return 8 * $urandom_range(max_bytes, 1);
  endfunction

  // sync, nbits data bits, then the closing high gap
  task automatic send_frame(input int nbits);
    int span, off, hmax;
    send_run(1'b1, $urandom_range(3, 1));
    span = below_set - above_set - 1;
    if (span > 0) begin
      if ($urandom_range(3) == 0) off = $urandom_range(span - 1);
      else off = $urandom_range((span - 1 < 6) ? span - 1 : 6);
      send_run(1'b0, above_set + off + 2);
    end else begin
      send_run(1'b0, $urandom_range(40, 1));
    end
    // high between bits must stay below the end gap
    hmax = (gap_set == 0) ? 1 : ((gap_set < 3) ? gap_set : 3);
    for (int i = 0; i < nbits; i++) begin
      send_run(1'b1, $urandom_range(hmax, 1));
      send_run(1'b0, bit_low_len() + 1);
    end
    send_run(1'b1, gap_set + 1 + $urandom_range(3));
  endtask

  // random runs, then a gap long enough to close anything it opened
  task automatic send_noise();
    repeat ($urandom_range(12, 3)) send_run(1'($urandom_range(1)), $urandom_range(8, 1));
    if ($urandom_range(9) == 0) send_run(1'b0, 300);
    send_run(1'b1, gap_set + 2);
  endtask

  task automatic run_phase(input logic [7:0] z, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] g, input int sidle, input int rstall,
                           input int nframes, input int max_bytes);
    wait_idle();
    apply_settings(z, a, b, g);
    send_idle_pct = sidle;
    stall_pct    <= rstall;
    repeat (nframes) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_frame(pick_bits(max_bytes));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: tight window so short frames fit
    apply_settings(8'd2, 8'd1, 8'd4, 8'd3);
    send_run(1'b1, 1);    // first sample high: rising edge with zero low length
    send_run(1'b0, 3);    // low length 2 is a sync
    for (int i = 0; i < 8; i++) begin
      send_run(1'b1, 1);
      send_run(1'b0, DIR_BYTE[i] ? 1 : 3);
    end
    send_run(1'b1, 4);    // aligned frame end
    send_run(1'b0, 3);
    send_run(1'b1, 4);    // empty frame is an error

    run_phase(8'd3,   8'd25,  8'd45,  8'd40,  0,  0,  1, 1);
    run_phase(8'd2,   8'd2,   8'd6,   8'd5,   52, 0,  2, 1);
    run_phase(8'd3,   8'd0,   8'd4,   8'd2,   0,  52, 2, 1);
    run_phase(8'd1,   8'd1,   8'd3,   8'd1,   9,  9,  2, 1);
    run_phase(8'd0,   8'd0,   8'd255, 8'd0,   0,  0,  1, 1);
    run_phase(8'd255, 8'd0,   8'd255, 8'd255, 0,  0,  1, 1);
    // sync window empty: nothing may open
    run_phase(8'd2,   8'd255, 8'd0,   8'd3,   52, 52, 2, 1);

    // long receiver hold-off while samples keep coming
    wait_idle();
    apply_settings(8'd1, 8'd0, 8'd3, 8'd2);
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_req     <= 1'b1;
    repeat (2) send_frame(16);

    run_phase(8'd3, 8'd10, 8'd20, 8'd8, 52, 52, 2, 2);
    while (ticks_sent < ITEM_TARGET) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_frame(pick_bits(2));
    end

    wait_idle();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pwfr_pkg.sv
design/pulse_width_frame_receiver.sv
design/pwfr_checker.sv
tb/frame_event_checker.sv
tb/tb.sv
